@@ hdl/rcoc_pkg.sv @@
// Shared types, constants and constant tables for the class/offset coder.
`timescale 1ns / 1ps

package rcoc_pkg;

  // Block geometry and field widths.
  localparam int BLOCK_BITS  = 15;
  localparam int CLS_W       = 4;   // class field and bit-position index width
  localparam int OFF_W       = 13;  // offset field width
  localparam int STAGE_STEPS = 3;   // bit positions handled by one pipeline stage
  localparam int NUM_STAGES  = BLOCK_BITS / STAGE_STEPS;

  // Binomial coefficients C(n, k) for n, k in 0..BLOCK_BITS; zero where k > n.
  typedef logic [BLOCK_BITS:0][BLOCK_BITS:0][OFF_W-1:0] binom_tab_t;

  // Per-class entry: number of blocks in the class and the offset length.
  typedef struct packed {
    logic [OFF_W-1:0] size;
    logic [CLS_W-1:0] obits;
  } rcoc_class_t;

  typedef rcoc_class_t [BLOCK_BITS:0] class_tab_t;

  // Payload that travels down the pipeline.
  typedef struct packed {
    logic             mode;    // 0 encode, 1 decode
    logic [14:0]      block;   // input block, echoed in encode mode
    logic [CLS_W-1:0] ones;    // class
    logic [OFF_W-1:0] offset;  // encode accumulator, decode echo
    logic [CLS_W-1:0] seen;    // encode: ones seen so far
    logic [CLS_W-1:0] left;    // decode: ones still to place
    logic [OFF_W-1:0] rem;     // decode: remaining rank
    logic [14:0]      built;   // decode: block under construction
    logic             bad;     // decode offset out of range
    logic [CLS_W-1:0] obits;   // offset length for the class
  } rcoc_item_t;

  // Pascal's triangle, evaluated at elaboration.
  function automatic binom_tab_t build_binom();
    binom_tab_t t;
    t = '0;
    for (int n = 0; n <= BLOCK_BITS; n++) begin
      t[n][0] = OFF_W'(1);
      for (int k = 1; k <= n; k++) begin
        t[n][k] = t[n-1][k-1] + t[n-1][k];
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM = build_binom();

  // Class size and offset length, ceil(log2(size)) but at least one bit.
  function automatic class_tab_t build_class();
    class_tab_t t;
    int         b;
    int         c;
    t = '0;
    for (int k = 0; k <= BLOCK_BITS; k++) begin
      c = int'(BINOM[BLOCK_BITS][k]);
      b = 1;
      for (int i = 1; i < OFF_W; i++) begin
        if ((1 << b) < c) begin
          b = b + 1;
        end
      end
      t[k].size  = BINOM[BLOCK_BITS][k];
      t[k].obits = CLS_W'(b);
    end
    return t;
  endfunction

  localparam class_tab_t CLASS_TAB = build_class();

endpackage

@@ hdl/rcoc_class_rom.sv @@
// Class table memory: class size and offset length, with a registered read.
`timescale 1ns / 1ps

module rcoc_class_rom (
  input  logic                           clk,
  input  logic                           en,
  input  logic [rcoc_pkg::CLS_W-1:0]     addr,
  output rcoc_pkg::rcoc_class_t          rd_data
);

  rcoc_pkg::rcoc_class_t mem [rcoc_pkg::BLOCK_BITS+1];

  always_comb begin
    for (int i = 0; i <= rcoc_pkg::BLOCK_BITS; i++) begin
      mem[i] = rcoc_pkg::CLASS_TAB[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

@@ hdl/rcoc_stage.sv @@
// One ranking pipeline stage: three encode and decode bit positions per stage.
`timescale 1ns / 1ps

module rcoc_stage #(
  parameter int STAGE = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rcoc_pkg::rcoc_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rcoc_pkg::rcoc_item_t  out_item
);

  rcoc_pkg::rcoc_item_t item_next;

  // Encode walks positions upward, decode walks them downward.
  always_comb begin
    int                            p_enc;
    int                            p_dec;
    logic [rcoc_pkg::OFF_W-1:0]    c;
    item_next = in_item;
    p_enc     = 0;
    p_dec     = 0;
    c         = '0;
    for (int j = 0; j < rcoc_pkg::STAGE_STEPS; j++) begin
      p_enc = STAGE * rcoc_pkg::STAGE_STEPS + j;
      p_dec = rcoc_pkg::BLOCK_BITS - 1 - p_enc;
      if (!item_next.mode) begin
        if (item_next.block[rcoc_pkg::CLS_W'(p_enc)]) begin
          item_next.seen   = item_next.seen + 1'b1;
          item_next.offset = item_next.offset
                           + rcoc_pkg::BINOM[rcoc_pkg::CLS_W'(p_enc)][item_next.seen];
        end
      end else if (item_next.left != '0) begin
        c = rcoc_pkg::BINOM[rcoc_pkg::CLS_W'(p_dec)][item_next.left];
        if (item_next.rem >= c) begin
          item_next.built[rcoc_pkg::CLS_W'(p_dec)] = 1'b1;
          item_next.rem  = item_next.rem - c;
          item_next.left = item_next.left - 1'b1;
        end
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

@@ hdl/rrr_class_offset_coder.sv @@
// Top level of the class/offset coder for 15-bit succinct bitvector blocks.
// A transaction accepted at the input passes through the input register and then
//   the five ranking stages before it is presented on the output.
// Throughput: one transaction per cycle unless the output stalls; each stage resolves three bit positions.
// Stalls only back up as far as the first empty stage, so bubbles are absorbed.
// Reset clears the valid flags of every stage; payload registers are not reset.
`timescale 1ns / 1ps

module rrr_class_offset_coder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [14:0] block_in,
  input  logic [3:0]  ones_in,
  input  logic [12:0] offset_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] block_out,
  output logic [3:0]  ones_out,
  output logic [12:0] offset_out,
  output logic [3:0]  offset_bits,
  output logic        bad_offset
);

  // The stage count follows from the block size and the positions per stage.
  localparam int NUM_STAGES = rcoc_pkg::NUM_STAGES;

  // The entry stage captures the transaction and looks up the class table.
  // The class is the popcount of the block in encode mode and ones_in in
  // decode mode, so the table read can start at the accepting edge.
  logic [rcoc_pkg::CLS_W-1:0] pop;
  logic [rcoc_pkg::CLS_W-1:0] cls;
  rcoc_pkg::rcoc_item_t       r0_item;
  rcoc_pkg::rcoc_item_t       r0_fill;
  logic                       r0_valid;
  logic                       r0_ready;
  logic                       accept;
  rcoc_pkg::rcoc_class_t      cls_info;

  // Pipeline chain: index 0 is the entry stage, index NUM_STAGES the output.
  logic                 chain_valid [NUM_STAGES+1];
  logic                 chain_ready [NUM_STAGES+1];
  rcoc_pkg::rcoc_item_t chain_item  [NUM_STAGES+1];

  always_comb begin
    pop = '0;
    for (int i = 0; i < rcoc_pkg::BLOCK_BITS; i++) begin
      pop = pop + rcoc_pkg::CLS_W'(block_in[i]);
    end
  end

  assign cls = mode ? ones_in : pop;

  // Starting values: encode accumulates from zero, decode places ones_in
  // ones while walking the rank downward from the top bit position.
  always_comb begin
    r0_fill        = '0;
    r0_fill.mode   = mode;
    r0_fill.block  = block_in;
    r0_fill.ones   = cls;
    r0_fill.offset = mode ? offset_in : '0;
    r0_fill.left   = ones_in;
    r0_fill.rem    = offset_in;
  end

  assign r0_ready = !r0_valid || chain_ready[0];
  assign in_ready = r0_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid <= 1'b0;
    end else if (r0_ready) begin
      r0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r0_item <= r0_fill;
    end
  end

  // The table read is enabled by the same accept as the entry register, so
  // its registered output always belongs to the transaction held there.
  rcoc_class_rom u_class_rom (
    .clk     (clk),
    .en      (accept),
    .addr    (cls),
    .rd_data (cls_info)
  );

  // An offset at or beyond the class size is flagged in decode mode only.
  always_comb begin
    chain_item[0]       = r0_item;
    chain_item[0].bad   = r0_item.mode && (r0_item.offset >= cls_info.size);
    chain_item[0].obits = cls_info.obits;
  end

  assign chain_valid[0] = r0_valid;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    rcoc_stage #(
      .STAGE (s)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[s]),
      .in_ready  (chain_ready[s]),
      .in_item   (chain_item[s]),
      .out_valid (chain_valid[s+1]),
      .out_ready (chain_ready[s+1]),
      .out_item  (chain_item[s+1])
    );
  end

  assign chain_ready[NUM_STAGES] = out_ready;
  assign out_valid               = chain_valid[NUM_STAGES];

  // A decode with a bad offset returns an all-zero block.
  assign block_out   = chain_item[NUM_STAGES].mode
                     ? (chain_item[NUM_STAGES].bad ? '0 : chain_item[NUM_STAGES].built)
                     : chain_item[NUM_STAGES].block;
  assign ones_out    = chain_item[NUM_STAGES].ones;
  assign offset_out  = chain_item[NUM_STAGES].offset;
  assign offset_bits = chain_item[NUM_STAGES].obits;
  assign bad_offset  = chain_item[NUM_STAGES].bad;

  // Encode results never carry the range flag.
  a_encode_not_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && !chain_item[NUM_STAGES].mode |-> !bad_offset)
    else $error("encode transaction flagged as bad offset");

  // The entry popcount and the per-stage count of ones must agree.
  a_encode_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && !chain_item[NUM_STAGES].mode |-> ones_out == chain_item[NUM_STAGES].seen)
    else $error("encode class disagrees with ones counted by the stages");

  // An in-range decode consumes the whole rank and places every one.
  a_decode_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && chain_item[NUM_STAGES].mode && !bad_offset
    |-> chain_item[NUM_STAGES].left == '0 && chain_item[NUM_STAGES].rem == '0)
    else $error("decode finished with rank or ones left over");

  // An in-range decode yields a block of the requested class.
  a_decode_popcount: assert property (@(posedge clk) disable iff (rst)
    out_valid && chain_item[NUM_STAGES].mode && !bad_offset
    |-> $countones(block_out) == int'(ones_out))
    else $error("decoded block popcount differs from class");

endmodule
